// ===== src/bpp_pkg.sv =====
// ----------------------------------------------------------------------------
// bpp_pkg
// Shared widths, constants and controller/datapath interface types for the
// basket performance payoff core.
// ----------------------------------------------------------------------------
`default_nettype none

package bpp_pkg;

  localparam int SPOT_W      = 32;
  localparam int WEIGHT_W    = 16;
  localparam int NUM_WEIGHTS = 8;
  localparam int IDX_W       = 3;
  localparam int CFG_ADDR_W  = 4;
  localparam int PROD_W      = SPOT_W + WEIGHT_W + 1;
  localparam int ACC_W       = 64;
  localparam int FRAC_W      = 16;
  localparam int SUM_W       = 40;
  localparam int OUT_W       = 32;
  localparam int INT_W       = SUM_W - FRAC_W;
  localparam int DIV_STEPS   = SUM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam int MAX_ASSETS_DEF = 8;

  localparam logic [SUM_W-1:0] ONE_Q16 = SUM_W'(1) << FRAC_W;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef struct packed {
    logic load;
    logic accum;
    logic check;
    logic div_step;
    logic add;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic close;
    logic end_path;
    logic div_go;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/bpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpp_ctrl
// Sequencer: accept a word, accumulate it, close the date (check, divide,
// add) and hand the payoff to the output register at path end.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  bpp_pkg::dp_stat_t   stat,
  output bpp_pkg::dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_CHECK,
    ST_DIV,
    ST_ADD,
    ST_EMIT
  } state_t;

  state_t                         state;
  logic [bpp_pkg::DIV_CNT_W-1:0]  div_cnt;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = in_ready && in_valid;
    cmd.accum    = (state == ST_ACC);
    cmd.check    = (state == ST_CHECK);
    cmd.div_step = (state == ST_DIV);
    cmd.add      = (state == ST_ADD);
    cmd.emit     = (state == ST_EMIT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_ACC;
        end
        ST_ACC: begin
          state <= stat.close ? ST_CHECK : ST_IDLE;
        end
        ST_CHECK: begin
          div_cnt <= bpp_pkg::DIV_CNT_W'(bpp_pkg::DIV_STEPS - 1);
          state   <= stat.div_go ? ST_DIV : ST_ADD;
        end
        ST_DIV: begin
          if (div_cnt == '0) begin
            state <= ST_ADD;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_ADD: begin
          state <= stat.end_path ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (stat.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt == '0) |=> (state == ST_ADD))
    else $error("divider did not hand over to add");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("emit while output register busy");

  a_load_acc: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_ACC && !in_ready))
    else $error("accepted word not accumulated");
`endif

endmodule

`default_nettype wire

// ===== src/bpp_datapath.sv =====
// ----------------------------------------------------------------------------
// bpp_datapath
// Weight registers, multiply-accumulate, period return by restoring
// division (one quotient bit per cycle), payoff sum and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpp_datapath #(
  parameter int MAX_ASSETS = bpp_pkg::MAX_ASSETS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  [bpp_pkg::CFG_ADDR_W-1:0]        cfg_addr,
  input  wire  [bpp_pkg::WEIGHT_W-1:0]          cfg_wdata,
  input  wire  [bpp_pkg::SPOT_W-1:0]            in_spot,
  input  wire                                   in_last_in_date,
  input  wire                                   in_last_of_path,
  input  bpp_pkg::dp_cmd_t                      cmd,
  output bpp_pkg::dp_stat_t                     stat,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [bpp_pkg::OUT_W-1:0]             out_payoff,
  output logic                                  out_bad
);

  localparam int ACC_W = bpp_pkg::ACC_W;
  localparam int SUM_W = bpp_pkg::SUM_W;
  localparam int INT_W = bpp_pkg::INT_W;
  localparam int FRAC_W = bpp_pkg::FRAC_W;
  localparam int PROD_W = bpp_pkg::PROD_W;

  logic signed [bpp_pkg::WEIGHT_W-1:0] weight [bpp_pkg::NUM_WEIGHTS];
  logic [bpp_pkg::IDX_W-1:0]           idx;
  logic signed [PROD_W-1:0]            product;
  logic signed [ACC_W-1:0]             basket;
  logic signed [ACC_W-1:0]             prev;
  logic                                have_prev;
  logic                                err;
  logic [SUM_W-1:0]                    payoff_sum;
  logic                                end_date;
  logic                                end_path;
  logic [ACC_W-1:0]                    den;
  logic [ACC_W-1:0]                    rem;
  logic [SUM_W-1:0]                    dvd;
  logic [SUM_W-1:0]                    quot;

  logic signed [PROD_W-1:0]            mul;
  logic [ACC_W-1:0]                    num;
  logic [SUM_W-1:0]                    num_hi;
  logic                                prev_pos;
  logic                                rising;
  logic                                ovf;
  logic [ACC_W:0]                      rem_sh;
  logic                                rem_ge;
  logic [SUM_W:0]                      sum_ext;

  assign mul      = $signed({1'b0, in_spot}) * weight[idx];
  assign num      = ACC_W'(basket - prev);
  assign num_hi   = num[ACC_W-1:INT_W];
  assign prev_pos = (prev > $signed(ACC_W'(0)));
  assign rising   = (basket >= prev);
  assign ovf      = ({{(ACC_W-SUM_W){1'b0}}, num_hi} >= $unsigned(prev));
  assign rem_sh   = {rem, dvd[SUM_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, den});
  assign sum_ext  = {1'b0, payoff_sum} + {1'b0, quot};

  assign stat.close    = end_date || end_path;
  assign stat.end_path = end_path;
  assign stat.div_go   = have_prev && prev_pos && rising && !ovf;
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bpp_pkg::NUM_WEIGHTS; i++) weight[i] <= '0;
    end else if (cfg_we && cfg_addr < bpp_pkg::CFG_ADDR_W'(bpp_pkg::NUM_WEIGHTS)) begin
      weight[cfg_addr[bpp_pkg::IDX_W-1:0]] <= cfg_wdata;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      product  <= mul;
      end_date <= in_last_in_date;
      end_path <= in_last_of_path;
    end
    if (cmd.check) begin
      den  <= $unsigned(prev);
      rem  <= {{(ACC_W-SUM_W){1'b0}}, num_hi};
      dvd  <= {num[INT_W-1:0], {FRAC_W{1'b0}}};
      quot <= (have_prev && prev_pos && rising && ovf) ? bpp_pkg::SUM_MAX : '0;
    end
    if (cmd.div_step) begin
      rem  <= rem_ge ? ACC_W'(rem_sh - {1'b0, den}) : rem_sh[ACC_W-1:0];
      dvd  <= dvd << 1;
      quot <= {quot[SUM_W-2:0], rem_ge};
    end
    if (cmd.emit) begin
      out_payoff <= (|payoff_sum[SUM_W-1:bpp_pkg::OUT_W]) ? bpp_pkg::OUT_MAX
                                                          : payoff_sum[bpp_pkg::OUT_W-1:0];
      out_bad    <= err;
    end
  end

  // path state
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      idx        <= '0;
      basket     <= '0;
      prev       <= '0;
      have_prev  <= 1'b0;
      err        <= 1'b0;
      payoff_sum <= bpp_pkg::ONE_Q16;
    end else begin
      if (cmd.accum) begin
        basket <= basket + {{(ACC_W-PROD_W){product[PROD_W-1]}}, product};
        idx    <= (idx == bpp_pkg::IDX_W'(MAX_ASSETS - 1)) ? '0 : idx + 1'b1;
      end
      if (cmd.check) begin
        if (have_prev && !prev_pos) err <= 1'b1;
        prev      <= basket;
        basket    <= '0;
        have_prev <= 1'b1;
        idx       <= '0;
      end
      if (cmd.add) begin
        payoff_sum <= sum_ext[SUM_W] ? bpp_pkg::SUM_MAX : sum_ext[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_payoff_floor: assert property (@(posedge clk) disable iff (rst)
    payoff_sum >= bpp_pkg::ONE_Q16)
    else $error("payoff sum dropped below one");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < den))
    else $error("partial remainder not below divisor");

  a_check_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.check |=> (basket == '0 && have_prev && idx == '0))
    else $error("date close left basket state");
`endif

endmodule

`default_nettype wire

// ===== src/basket_performance_payoff_core.sv =====
// ----------------------------------------------------------------------------
// basket_performance_payoff_core
// Weighted basket per date, sum of positive period returns, payoff in Q16.16
// with a bad-basket flag at the end of each path.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata spot, tuser last_in_date,
//                                        tlast last_of_path
// m_axis    out  m_axis_tvalid/tready    tdata payoff, tuser bad_basket
// cfg       in   cfg_we (no wait)        cfg_addr index, cfg_wdata weight
//
// A word that does not end a date goes through multiply and accumulate.
// A date-ending word then goes through check, divide (when the return is
// divided; the restoring divider yields one quotient bit per cycle) and add.
// A path-ending word adds an emit state and waits there until the output
// register is free.
// Reset (rst, synchronous) clears weights and path state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module basket_performance_payoff_core #(
  parameter int MAX_ASSETS = bpp_pkg::MAX_ASSETS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [bpp_pkg::SPOT_W-1:0]         s_axis_tdata,   // [31:0] spot
  input  wire                                s_axis_tuser,   // [0] last_in_date
  input  wire                                s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [bpp_pkg::OUT_W-1:0]          m_axis_tdata,   // [31:0] payoff
  output logic                               m_axis_tuser,   // [0] bad_basket
  input  wire                                cfg_we,
  input  wire  [bpp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [bpp_pkg::WEIGHT_W-1:0]       cfg_wdata
);

  bpp_pkg::dp_cmd_t  cmd;
  bpp_pkg::dp_stat_t stat;

  bpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bpp_datapath #(
    .MAX_ASSETS (MAX_ASSETS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_spot         (s_axis_tdata),
    .in_last_in_date (s_axis_tuser),
    .in_last_of_path (s_axis_tlast),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_payoff      (m_axis_tdata),
    .out_bad         (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for basket_performance_payoff_core. Price paths go in
// on the stream input and payoff words come out on the stream output. A
// bit-true shadow model predicts each payoff word, and a queue holds the
// payoffs due so that each output word is checked in order.
// A directed table covers the extreme spots, asset wrap inside a date,
// path end without date end, bad previous baskets, single-date paths and
// ignored register writes. Random paths then run under several weight sets,
// most with random stalls on both sides, and with one long output stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int SEG_WORDS    = 170;
  localparam int NUM_SEGS     = 6;

  localparam logic [bpp_pkg::CFG_ADDR_W-1:0] REG_WEIGHT_0 = 4'd0;
  localparam logic [bpp_pkg::CFG_ADDR_W-1:0] REG_SPARE_LO = 4'd8;
  localparam logic [bpp_pkg::CFG_ADDR_W-1:0] REG_SPARE_HI = 4'd15;

  localparam logic [bpp_pkg::WEIGHT_W-1:0] W_ONE = 16'h1000;
  localparam logic [bpp_pkg::WEIGHT_W-1:0] W_MAX = 16'h7FFF;
  localparam logic [bpp_pkg::WEIGHT_W-1:0] W_MIN = 16'h8000;

  typedef struct packed {
    logic [bpp_pkg::OUT_W-1:0] payoff;
    logic                      bad;
  } payoff_res_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [bpp_pkg::CFG_ADDR_W-1:0] addr;
    logic [bpp_pkg::WEIGHT_W-1:0]   wdata;
    logic [bpp_pkg::SPOT_W-1:0]     spot;
    logic                           eod;
    logic                           eop;
    logic                           known;
    payoff_res_t                    res;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [bpp_pkg::SPOT_W-1:0]     s_axis_tdata = '0;   // [31:0] spot
  logic                           s_axis_tuser = 1'b0; // [0] last_in_date
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [bpp_pkg::OUT_W-1:0]      m_axis_tdata;        // [31:0] payoff
  logic                           m_axis_tuser;        // [0] bad_basket
  logic                           cfg_we = 1'b0;
  logic [bpp_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [bpp_pkg::WEIGHT_W-1:0]   cfg_wdata = '0;

  basket_performance_payoff_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow model state
  logic signed [bpp_pkg::WEIGHT_W-1:0] weight_shadow [bpp_pkg::NUM_WEIGHTS];
  longint                              basket_acc;
  longint                              prev_basket;
  logic [63:0]                         payoff_acc;
  int unsigned                         asset_pos;
  bit                                  have_prev;
  bit                                  bad_seen;

  payoff_res_t payoff_due_q [$];
  int          send_idle_pct = 32;
  int          recv_idle_pct = 69;
  bit          hold_req = 1'b0;
  int          fail_cnt = 0;
  int          words_sent = 0;

  function automatic void clear_path_state();
    basket_acc  = 0;
    prev_basket = 0;
    payoff_acc  = 64'(bpp_pkg::ONE_Q16);
    asset_pos   = 0;
    have_prev   = 1'b0;
    bad_seen    = 1'b0;
  endfunction

  // floor(num * 2^16 / den), saturated to the sum ceiling
  function automatic logic [bpp_pkg::SUM_W-1:0] period_gain(logic [63:0] num,
                                                            logic [63:0] den);
    logic [127:0] quot;
    quot = (128'(num) << bpp_pkg::FRAC_W) / 128'(den);
    if (quot > 128'(bpp_pkg::SUM_MAX)) return bpp_pkg::SUM_MAX;
    return quot[bpp_pkg::SUM_W-1:0];
  endfunction

  function automatic bit predict_payoff(logic [bpp_pkg::SPOT_W-1:0] spot, bit eod, bit eop,
                                        output payoff_res_t res);
    res = '0;
    basket_acc += longint'(spot) *
                  longint'(weight_shadow[asset_pos[bpp_pkg::IDX_W-1:0]]);
    asset_pos = (asset_pos + 1) % bpp_pkg::NUM_WEIGHTS;
    if (eod || eop) begin
      if (have_prev) begin
        if (prev_basket <= 0) begin
          bad_seen = 1'b1;
        end else if (basket_acc >= prev_basket) begin
          payoff_acc += 64'(period_gain(basket_acc - prev_basket, prev_basket));
          if (payoff_acc > 64'(bpp_pkg::SUM_MAX)) payoff_acc = 64'(bpp_pkg::SUM_MAX);
        end
      end
      prev_basket = basket_acc;
      have_prev   = 1'b1;
      basket_acc  = 0;
      asset_pos   = 0;
    end
    if (!eop) return 1'b0;
    res.payoff = (payoff_acc > 64'(bpp_pkg::OUT_MAX)) ? bpp_pkg::OUT_MAX
                                                      : payoff_acc[bpp_pkg::OUT_W-1:0];
    res.bad    = bad_seen;
    clear_path_state();
    return 1'b1;
  endfunction

  function automatic stim_row_t word_row(logic [bpp_pkg::SPOT_W-1:0] spot, bit eod, bit eop);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.spot = spot;
    r.eod  = eod;
    r.eop  = eop;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [bpp_pkg::SPOT_W-1:0] spot, bit eod, bit eop,
                                          logic [bpp_pkg::OUT_W-1:0] payoff, bit bad);
    stim_row_t r;
    r = word_row(spot, eod, eop);
    r.known      = 1'b1;
    r.res.payoff = payoff;
    r.res.bad    = bad;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [bpp_pkg::CFG_ADDR_W-1:0] addr,
                                        logic [bpp_pkg::WEIGHT_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.kind  = ROW_CFG;
    r.addr  = addr;
    r.wdata = data;
    return r;
  endfunction

  function automatic logic [bpp_pkg::SPOT_W-1:0] pick_spot(logic [15:0] lvl);
    case ($urandom_range(29))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom();
      default: return {lvl + 16'($urandom_range(0, 15)), 16'($urandom())};
    endcase
  endfunction

  function automatic logic [bpp_pkg::WEIGHT_W-1:0] pick_weight(int seg, int r);
    case (seg)
      0:       return W_ONE;
      1, 4:    return 16'($urandom_range(16'h0400, 16'h3FFF));
      3: begin
        case (r)
          3:       return W_MIN;
          5:       return 16'h0000;
          7:       return 16'hFFFF;
          default: return W_MAX;
        endcase
      end
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_word(logic [bpp_pkg::SPOT_W-1:0] spot, bit eod, bit eop,
                           bit known = 1'b0, payoff_res_t known_res = '0);
    payoff_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= spot;
    s_axis_tuser  <= eod;
    s_axis_tlast  <= eop;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    if (predict_payoff(spot, eod, eop, res)) payoff_due_q.push_back(known ? known_res : res);
  endtask

  task automatic write_reg(logic [bpp_pkg::CFG_ADDR_W-1:0] addr,
                           logic [bpp_pkg::WEIGHT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    if (addr < bpp_pkg::NUM_WEIGHTS) weight_shadow[addr[bpp_pkg::IDX_W-1:0]] = data;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (payoff_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_path(int unsigned width);
    int unsigned dates;
    int unsigned n;
    logic [15:0] lvl;
    bit          open_end;
    lvl = 16'($urandom_range(16'h0100, 16'h8000));
    if ($urandom_range(9) == 0) begin
      // noise: date marks at random
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) send_word(pick_spot(lvl), $urandom_range(2) == 0, i == n - 1);
      return;
    end
    dates    = $urandom_range(1, 6);
    open_end = ($urandom_range(3) == 0);
    for (int d = 0; d < dates; d++) begin
      n = width;
      case ($urandom_range(7))
        0: n = width + $urandom_range(1, 4);
        1: n = $urandom_range(1, width);
        default: ;
      endcase
      for (int a = 0; a < n; a++) begin
        send_word(pick_spot(lvl),
                  (a == n - 1) && !(d == dates - 1 && open_end),
                  (a == n - 1) && (d == dates - 1));
      end
      lvl = lvl + 16'($urandom_range(0, 40)) - 16'd20;
    end
  endtask

  always @(posedge clk) begin : rx_check
    payoff_res_t want;
    int          hold_left;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (payoff_due_q.size() == 0) begin
        $display("%0t: unexpected payoff word: expected none, actual %h bad %b",
                 $time, m_axis_tdata, m_axis_tuser);
        fail_cnt++;
      end else begin
        want = payoff_due_q.pop_front();
        if (want.payoff !== m_axis_tdata) begin
          $display("%0t: payoff mismatch: expected %h, actual %h",
                   $time, want.payoff, m_axis_tdata);
          fail_cnt++;
        end
        if (want.bad !== m_axis_tuser) begin
          $display("%0t: bad_basket mismatch: expected %b, actual %b",
                   $time, want.bad, m_axis_tuser);
          fail_cnt++;
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("basket_performance_payoff_core verification failed");
    $finish;
  end

  initial begin
    stim_row_t   rows [$];
    row_kind_t   prev_kind;
    int          seg_start;

    for (int i = 0; i < bpp_pkg::NUM_WEIGHTS; i++) weight_shadow[i] = '0;
    clear_path_state();

    // weights are zero after reset
    rows.push_back(known_row(32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0001_0000, 1'b0));
    rows.push_back(word_row(32'h1234_5678, 1'b1, 1'b0));
    rows.push_back(known_row(32'h0000_0000, 1'b0, 1'b1, 32'h0001_0000, 1'b1));
    for (int i = 0; i < bpp_pkg::NUM_WEIGHTS; i++) begin
      rows.push_back(reg_row(REG_WEIGHT_0 + 4'(i), W_ONE));
    end
    // rise, then fall; path closed without date mark
    rows.push_back(word_row(32'h0001_0000, 1'b1, 1'b0));
    rows.push_back(word_row(32'h0002_0000, 1'b1, 1'b0));
    rows.push_back(word_row(32'h0001_0000, 1'b0, 1'b1));
    // tiny basket then huge one: increment saturates
    rows.push_back(word_row(32'h0000_0001, 1'b1, 1'b0));
    rows.push_back(known_row(32'hFFFF_FFFF, 1'b1, 1'b1, bpp_pkg::OUT_MAX, 1'b0));
    // nine assets in one date: the ninth reuses weight_0
    for (int i = 0; i < 8; i++) rows.push_back(word_row(32'h0001_0000, 1'b0, 1'b0));
    rows.push_back(word_row(32'h0003_0000, 1'b1, 1'b0));
    rows.push_back(word_row(32'h0010_0000, 1'b1, 1'b1));
    rows.push_back(reg_row(REG_WEIGHT_0, W_MIN));
    rows.push_back(reg_row(REG_WEIGHT_0 + 4'd1, W_MAX));
    rows.push_back(reg_row(REG_SPARE_LO + 4'd1, 16'h1234));
    // negative previous basket
    rows.push_back(word_row(32'hFFFF_FFFF, 1'b1, 1'b0));
    rows.push_back(known_row(32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000, 1'b1));
    // flat return with extreme weights
    rows.push_back(word_row(32'h0000_0000, 1'b0, 1'b0));
    rows.push_back(word_row(32'hFFFF_FFFF, 1'b1, 1'b0));
    rows.push_back(word_row(32'h0000_0000, 1'b0, 1'b0));
    rows.push_back(word_row(32'hFFFF_FFFF, 1'b1, 1'b1));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    prev_kind = ROW_CFG;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (prev_kind == ROW_WORD) drain();
        write_reg(rows[i].addr, rows[i].wdata);
      end else begin
        send_word(rows[i].spot, rows[i].eod, rows[i].eop, rows[i].known, rows[i].res);
      end
      prev_kind = rows[i].kind;
    end

    for (int seg = 0; seg < NUM_SEGS; seg++) begin
      drain();
      case (seg)
        0, 1:    begin send_idle_pct = 32; recv_idle_pct = 69; end
        2, 3:    begin send_idle_pct = 69; recv_idle_pct = 32; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      for (int r = 0; r < bpp_pkg::NUM_WEIGHTS; r++) begin
        write_reg(REG_WEIGHT_0 + 4'(r), pick_weight(seg, r));
      end
      write_reg(4'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom()));
      // long output stall so the core backs up into its input
      if (seg == 4) hold_req = 1'b1;
      seg_start = words_sent;
      while (words_sent - seg_start < SEG_WORDS) begin
        send_path($urandom_range(1, bpp_pkg::NUM_WEIGHTS));
      end
    end

    drain();
    if (fail_cnt == 0) begin
      $display("basket_performance_payoff_core verification clean");
    end else begin
      $display("basket_performance_payoff_core verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bpp_pkg.sv
src/bpp_ctrl.sv
src/bpp_datapath.sv
src/basket_performance_payoff_core.sv
tb/tb.sv
